// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/lfu_pkg.sv =====
`default_nettype none
package lfu_pkg;
	localparam int Capacity  = 16;
	localparam int CountBits = 16;
	localparam int IdxW      = $clog2(Capacity);
	localparam int OccW      = $clog2(Capacity + 1);
	localparam int RankW     = (IdxW > 0) ? IdxW : 1;
	localparam logic [CountBits-1:0] CountMax = '1;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch request word
		logic search;    // register match and victim search
		logic update;    // apply state change and present result
	} lfu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic dummy;
	} lfu_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lfu_ctrl.sv =====
`default_nettype none
module lfu_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	output lfu_pkg::lfu_cmd_t    cmd
);
	import lfu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (start) state_q <= ST_SEARCH;
				ST_SEARCH: state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.search  = (state_q == ST_SEARCH);
	assign cmd.update  = (state_q == ST_UPDATE);
endmodule
`default_nettype wire

// ===== hw/rtl/lfu_datapath.sv =====
`default_nettype none
module lfu_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lfu_pkg::lfu_cmd_t  cmd,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata,
	input  wire logic               operation,
	input  wire logic [31:0]        key,
	input  wire logic [31:0]        write_value,
	output logic                    done,
	output logic                    found,
	output logic [31:0]             read_value,
	output logic                    evicted,
	output logic [31:0]             evicted_key
);
	import lfu_pkg::*;

	logic [4:0]              cap_q;
	logic [OccW-1:0]         occ_q;
	logic [Capacity-1:0]     valid_q;
	logic [31:0]             key_q   [Capacity];
	logic [31:0]             val_q   [Capacity];
	logic [CountBits-1:0]    cnt_q   [Capacity];
	logic [RankW-1:0]        rank_q  [Capacity];

	logic        op_q;
	logic [31:0] rkey_q, rval_q;

	// search results, registered
	logic            hit_q;
	logic [IdxW-1:0] hit_idx_q;
	logic            vic_ok_q;
	logic [IdxW-1:0] vic_idx_q;
	logic            free_ok_q;
	logic [IdxW-1:0] free_idx_q;

	logic            hit_c, free_c, vic_c;
	logic [IdxW-1:0] hit_idx_c, free_idx_c, vic_idx_c;
	logic [OccW-1:0] cap_eff;

	// victim search tree: leaves at Capacity..2*Capacity-1, root at 1
	logic                 vt_ok   [2*Capacity];
	logic [CountBits-1:0] vt_cnt  [2*Capacity];
	logic [RankW-1:0]     vt_rank [2*Capacity];
	logic [IdxW-1:0]      vt_idx  [2*Capacity];

	always_comb begin
		hit_c = 1'b0;  hit_idx_c = '0;
		free_c = 1'b0; free_idx_c = '0;
		for (int j = Capacity - 1; j >= 0; j--) begin
			if (valid_q[j] && key_q[j] == rkey_q) begin
				hit_c = 1'b1; hit_idx_c = IdxW'(j);
			end
			if (!valid_q[j]) begin
				free_c = 1'b1; free_idx_c = IdxW'(j);
			end
		end
	end

	// victim: lowest count, then highest rank (ranks of valid entries are distinct)
	always_comb begin
		for (int i = 0; i < 2 * Capacity; i++) begin
			vt_ok[i] = 1'b0; vt_cnt[i] = '0; vt_rank[i] = '0; vt_idx[i] = '0;
		end
		for (int j = 0; j < Capacity; j++) begin
			vt_ok[Capacity + j]   = valid_q[j];
			vt_cnt[Capacity + j]  = cnt_q[j];
			vt_rank[Capacity + j] = rank_q[j];
			vt_idx[Capacity + j]  = IdxW'(j);
		end
		for (int i = Capacity - 1; i >= 1; i--) begin
			if (vt_ok[2*i] && (!vt_ok[2*i+1] || vt_cnt[2*i] < vt_cnt[2*i+1] ||
			    (vt_cnt[2*i] == vt_cnt[2*i+1] && vt_rank[2*i] > vt_rank[2*i+1]))) begin
				vt_ok[i] = 1'b1; vt_cnt[i] = vt_cnt[2*i];
				vt_rank[i] = vt_rank[2*i]; vt_idx[i] = vt_idx[2*i];
			end else begin
				vt_ok[i] = vt_ok[2*i+1]; vt_cnt[i] = vt_cnt[2*i+1];
				vt_rank[i] = vt_rank[2*i+1]; vt_idx[i] = vt_idx[2*i+1];
			end
		end
		vic_c     = vt_ok[1];
		vic_idx_c = vt_idx[1];
	end

	assign cap_eff = (32'(cap_q) > Capacity) ? OccW'(Capacity) : OccW'(cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 5'd16;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= operation; rkey_q <= key; rval_q <= write_value;
		end
		if (cmd.search) begin
			hit_q <= hit_c; hit_idx_q <= hit_idx_c;
			vic_ok_q <= vic_c; vic_idx_q <= vic_idx_c;
			free_ok_q <= free_c; free_idx_q <= free_idx_c;
		end
	end

	logic do_touch, do_evict, do_insert;
	logic [IdxW-1:0] ins_idx;
	logic [RankW-1:0] touch_r, vic_r;
	always_comb begin
		do_touch  = hit_q && (op_q == OP_GET || cap_eff != '0);
		do_evict  = op_q == OP_PUT && cap_eff != '0 && !hit_q && occ_q >= cap_eff && vic_ok_q;
		do_insert = op_q == OP_PUT && cap_eff != '0 && !hit_q && (do_evict || free_ok_q);
		ins_idx   = do_evict ? vic_idx_q : free_idx_q;
		touch_r   = rank_q[hit_idx_q];
		vic_r     = rank_q[vic_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (cmd.update && do_insert && !do_evict) begin
			valid_q[ins_idx] <= 1'b1;
			occ_q <= occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int j = 0; j < Capacity; j++) begin
				if (do_touch && valid_q[j] && rank_q[j] < touch_r)
					rank_q[j] <= rank_q[j] + 1'b1;
				// evict then insert: older than victim keep rank, newer age by one
				if (do_insert && valid_q[j] && !(do_evict && (IdxW'(j) == ins_idx)) &&
				    !(do_evict && rank_q[j] > vic_r))
					rank_q[j] <= rank_q[j] + 1'b1;
			end
			if (do_touch) begin
				rank_q[hit_idx_q] <= '0;
				if (cnt_q[hit_idx_q] != CountMax)
					cnt_q[hit_idx_q] <= cnt_q[hit_idx_q] + 1'b1;
				if (op_q == OP_PUT) val_q[hit_idx_q] <= rval_q;
			end
			if (do_insert) begin
				key_q[ins_idx]  <= rkey_q;
				val_q[ins_idx]  <= rval_q;
				cnt_q[ins_idx]  <= CountBits'(1);
				rank_q[ins_idx] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= cmd.update;
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			found       <= hit_q;
			read_value  <= (op_q == OP_GET && hit_q) ? val_q[hit_idx_q] : 32'd0;
			evicted     <= do_evict;
			evicted_key <= do_evict ? key_q[vic_idx_q] : 32'd0;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lfu_cache_lookup_update.sv =====
// channel   | handshake              | ports
// request   | start & !busy          | operation, key, write_value
// result    | done (one cycle)       | found, read_value, evicted, evicted_key
// config    | cfg_we                 | cfg_wdata (capacity_in_use)
// A word is searched the cycle after acceptance and applied the cycle after that.
// done is registered from the apply step; no new word is taken until the last one has been applied.
// busy is high while a word is being searched and applied; the result cannot be stalled.
// Reset clears all entries at once; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module lfu_cache_lookup_update (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        operation,
	input  wire logic [31:0] key,
	input  wire logic [31:0] write_value,
	output logic             done,
	output logic             found,
	output logic [31:0]      read_value,
	output logic             evicted,
	output logic [31:0]      evicted_key
);
	import lfu_pkg::*;

	lfu_cmd_t cmd;
	logic     ctrl_busy;

	lfu_ctrl u_ctrl (.clk, .arst_n, .start, .busy(ctrl_busy), .cmd);

	lfu_datapath u_dp (
		.clk, .arst_n, .cmd, .cfg_we, .cfg_wdata, .operation, .key, .write_value,
		.done, .found, .read_value, .evicted, .evicted_key
	);

	assign busy = ctrl_busy;

	`ASSERT_IMPL(a_done_after_update, clk, arst_n, cmd.update |=> done, "result missing")
	`ASSERT_NEVER(a_evict_on_get, clk, arst_n, done && evicted && read_value != 32'd0, "evict on get")
	`ASSERT_IMPL(a_one_cmd, clk, arst_n, $onehot0({cmd.capture, cmd.search, cmd.update}), "overlapping commands")
endmodule
`default_nettype wire
